/* design/odo_pkg.sv */
// Shared constants, tables and types for the differential-drive odometry block.
package odo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // Multiplier operand and product widths
  localparam int unsigned MUL_AW = 44;
  localparam int unsigned MUL_BW = 32;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // Divider widths: 64-bit magnitude over a divisor up to 4095 * 512
  localparam int unsigned DIV_NW = 64;
  localparam int unsigned DIV_DW = 21;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0]        INV_PI_Q32      = 32'd1367130551;

  localparam logic [23:0] SCALE_RST = 24'd271790;
  localparam logic [11:0] BASE_RST  = 12'd217;
  localparam logic [15:0] RATE_RST  = 16'd250;

  localparam logic [1:0] CFG_SCALE = 2'd0;
  localparam logic [1:0] CFG_BASE  = 2'd1;
  localparam logic [1:0] CFG_RATE  = 2'd2;

  // atan(2^-i) as a binary angle, 2^31 = pi
  localparam logic [30:0] ATAN_BAM [32] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
    31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
    31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
    31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163,
    31'd81, 31'd41, 31'd20, 31'd10, 31'd5, 31'd3, 31'd1, 31'd1, 31'd0
  };

  typedef struct packed {
    logic start;
    logic b_signed;
  } mul_req_t;

endpackage

/* design/odo_mul.sv */
// Bit-serial shift-add multiplier: signed A times B, one bit of B per cycle.
module odo_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  odo_pkg::mul_req_t                   req_i,
  input  logic signed [odo_pkg::MUL_AW-1:0]   a_i,
  input  logic        [odo_pkg::MUL_BW-1:0]   b_i,
  output logic                                done_o,
  output logic signed [odo_pkg::MUL_PW-1:0]   prod_o
);
  import odo_pkg::*;

  localparam int unsigned HW = MUL_AW + 2;
  localparam int unsigned CW = $clog2(MUL_BW);
  localparam logic [CW-1:0] LAST = CW'(MUL_BW - 1);

  logic                 busy_q, done_q, bs_q;
  logic [CW-1:0]        cnt_q;
  logic [MUL_AW-1:0]    a_q;
  logic [HW-1:0]        hi_q;
  logic [MUL_BW-1:0]    lo_q;
  logic [HW-1:0]        a_ext, addend, sum;
  logic                 last;

  always_comb begin
    a_ext  = {{2{a_q[MUL_AW-1]}}, a_q};
    last   = (cnt_q == LAST);
    addend = '0;
    if (lo_q[0]) begin
      addend = (last && bs_q) ? (~a_ext + HW'(1)) : a_ext;
    end
    sum = hi_q + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= a_i;
      lo_q <= b_i;
      hi_q <= '0;
      bs_q <= req_i.b_signed;
    end else if (busy_q) begin
      hi_q <= {sum[HW-1], sum[HW-1:1]};
      lo_q <= {sum[0], lo_q[MUL_BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[MUL_AW-1:0], lo_q};

endmodule

/* design/odo_div.sv */
// Restoring divider: unsigned magnitude over unsigned divisor, one quotient bit per cycle.
module odo_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [odo_pkg::DIV_NW-1:0]   num_i,
  input  logic [odo_pkg::DIV_DW-1:0]   den_i,
  output logic                         done_o,
  output logic [odo_pkg::DIV_NW-1:0]   quo_o
);
  import odo_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW);
  localparam logic [CW-1:0] LAST = CW'(DIV_NW - 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [DIV_NW-1:0] num_q, quo_q;
  logic [DIV_DW-1:0] den_q, rem_q;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, num_q[DIV_NW-1]};
    ge    = (trial >= {1'b0, den_q});
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_NW-2:0], 1'b0};
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* design/odo_cordic.sv */
// Iterative CORDIC rotator: cos and sin of a binary angle, one rotation per cycle.
module odo_cordic #(
  parameter int unsigned STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import odo_pkg::*;

  localparam logic [4:0] LAST = 5'(STEPS - 1);

  logic               busy_q, done_q, flip_q;
  logic [4:0]         i_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic signed [33:0] xs, ys, at, x_n, y_n, z_n, xo, yo;
  logic               flip_in;

  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = {3'b000, ATAN_BAM[i_q]};
    if (!z_q[33]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
    // second and third quadrant fold by a half turn
    flip_in = angle_i[31] ^ angle_i[30];
    xo      = flip_q ? -x_q : x_q;
    yo      = flip_q ? -y_q : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= flip_in;
      x_q    <= CORDIC_GAIN_Q30;
      y_q    <= '0;
      z_q    <= {{2{angle_i[31] ^ flip_in}}, angle_i[31] ^ flip_in, angle_i[30:0]};
    end else if (busy_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
    end
  end

  assign done_o = done_q;
  assign cos_o  = xo[31:0];
  assign sin_o  = yo[31:0];

endmodule

/* design/differential_drive_odometry.sv */
// Differential-drive odometry top level: sequencer, serial arithmetic units, pose state.
// Schedule: 8 serial multiplies on the one shared bit-serial multiplier and 2 divisions on
//   the restoring divider, then the output state; CORDIC overlaps the multiplies.
// Inputs: one transaction at a time, taken only in idle; a new input is taken while a result waits.
// Reset: async active low; pose, stored counts and control clear, registers load defaults.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] right_count_i,
  input  logic signed [31:0] left_count_i,
  input  logic        restart_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] x_pos_o,
  output logic signed [31:0] y_pos_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] right_speed_o,
  output logic signed [31:0] left_speed_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] angular_speed_o
);
  import odo_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MGO   = 6'b000010,
    ST_MWAIT = 6'b000100,
    ST_DGO   = 6'b001000,
    ST_DWAIT = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  // multiply schedule, run in this order
  typedef enum logic [2:0] {
    OP_DR = 3'd0,  // right count delta * scale
    OP_DL = 3'd1,  // left count delta * scale
    OP_VR = 3'd2,  // right delta * rate
    OP_VL = 3'd3,  // left delta * rate
    OP_OM = 3'd4,  // clamped diff * rate
    OP_TH = 3'd5,  // clamped diff * 2^32/pi
    OP_MC = 3'd6,  // mean delta * cos
    OP_MS = 3'd7   // mean delta * sin
  } op_e;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    else if (v < -64'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [42:0] clamp43(input logic signed [42:0] v,
                                                 input logic signed [42:0] lim);
    if (v > lim) return lim;
    else if (v < -lim) return -lim;
    else return v;
  endfunction

  // pose + round(m * trig / 2^30), saturated
  function automatic logic [31:0] pos_step(input logic signed [31:0] p,
                                           input logic signed [MUL_PW-1:0] prod);
    logic signed [MUL_PW-1:0] t;
    logic signed [46:0]       s;
    t = prod + MUL_PW'(64'd536870912);
    s = {t[MUL_PW-1], t[MUL_PW-1:30]} + {{15{p[31]}}, p};
    return sat32({{17{s[46]}}, s});
  endfunction

  state_e state_q;
  op_e    op_q;
  logic   div_sel_q, div_neg_q;

  logic [23:0] scale_q;
  logic [11:0] base_q;
  logic [15:0] rate_q;

  logic [31:0] last_r_q, last_l_q, pose_x_q, pose_y_q, pose_h_q;

  logic signed [33:0] dcnt_r_q, dcnt_l_q;
  logic signed [41:0] dr_q, dl_q;
  logic signed [57:0] vr_q, vl_q;
  logic signed [55:0] om_q;
  logic signed [63:0] th_q;
  logic [31:0]        omega_q, dth_q, nx_q, ny_q;

  logic        out_valid_q;
  logic [31:0] x_pos_q, y_pos_q, heading_q, rs_q, ls_q, lin_q, ang_q;

  logic in_acc, out_load;

  // arithmetic units
  mul_req_t                  mul_req;
  logic signed [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]         mul_b;
  logic                      mul_done;
  logic signed [MUL_PW-1:0]  mul_prod;
  logic                      div_start, div_done;
  logic [DIV_NW-1:0]         div_num, div_quo;
  logic [DIV_DW-1:0]         div_den;
  logic signed [63:0]        div_snum, div_sq;
  logic                      cord_done;
  logic signed [31:0]        cord_cos, cord_sin;

  logic signed [33:0] rc34, lc34, pr34, pl34;
  logic [11:0]        base_eff;
  logic signed [42:0] diff, msum, clamp38, clamp31, mclamp;
  logic signed [58:0] vsum;
  logic signed [MUL_PW-1:0] rnd_delta;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    // right count is negated so both wheels count forward
    rc34     = {{2{right_count_i[31]}}, right_count_i};
    lc34     = {{2{left_count_i[31]}}, left_count_i};
    pr34     = restart_i ? '0 : {{2{last_r_q[31]}}, last_r_q};
    pl34     = restart_i ? '0 : {{2{last_l_q[31]}}, last_l_q};
    base_eff = (base_q == '0) ? 12'd1 : base_q;

    diff    = {dr_q[41], dr_q} - {dl_q[41], dl_q};
    // signed sums so the halving shift floors
    msum    = ($signed({dr_q[41], dr_q}) + $signed({dl_q[41], dl_q})) >>> 1;
    clamp38 = clamp43(diff, 43'sh40_0000_0000);
    clamp31 = clamp43(diff, 43'sh00_8000_0000);
    mclamp  = clamp43(msum, 43'sh01_0000_0000);
    vsum    = ($signed({vr_q[57], vr_q}) + $signed({vl_q[57], vl_q})) >>> 1;
    rnd_delta = mul_prod + MUL_PW'(64'd32768);

    mul_req.start    = (state_q == ST_MGO) && (op_q != OP_MC || cord_done);
    mul_req.b_signed = (op_q == OP_MC) || (op_q == OP_MS);
    unique case (op_q)
      OP_DR: begin mul_a = {{10{dcnt_r_q[33]}}, dcnt_r_q}; mul_b = {8'd0, scale_q}; end
      OP_DL: begin mul_a = {{10{dcnt_l_q[33]}}, dcnt_l_q}; mul_b = {8'd0, scale_q}; end
      OP_VR: begin mul_a = {{2{dr_q[41]}}, dr_q};          mul_b = {16'd0, rate_q}; end
      OP_VL: begin mul_a = {{2{dl_q[41]}}, dl_q};          mul_b = {16'd0, rate_q}; end
      OP_OM: begin mul_a = {clamp38[42], clamp38};         mul_b = {16'd0, rate_q}; end
      OP_TH: begin mul_a = {clamp31[42], clamp31};         mul_b = INV_PI_Q32;      end
      OP_MC: begin mul_a = {mclamp[42], mclamp};           mul_b = cord_cos;        end
      OP_MS: begin mul_a = {mclamp[42], mclamp};           mul_b = cord_sin;        end
      default: begin mul_a = '0; mul_b = '0; end
    endcase

    // signed numerator and divisor; the divider sees magnitudes only
    div_start = (state_q == ST_DGO);
    div_snum  = div_sel_q ? th_q : {om_q, 8'd0};
    div_num   = div_snum[63] ? -div_snum : div_snum;
    div_den   = div_sel_q ? {base_eff, 9'd0} : {9'd0, base_eff};
    div_sq    = div_neg_q ? -div_quo : div_quo;
  end

  odo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  odo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // rotates with the heading of the previous step, started at input accept
  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .angle_i (pose_h_q),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  // sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DR;
      div_sel_q   <= 1'b0;
      scale_q     <= SCALE_RST;
      base_q      <= BASE_RST;
      rate_q      <= RATE_RST;
      last_r_q    <= '0;
      last_l_q    <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_h_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SCALE) scale_q <= cfg_wdata_i;
        else if (cfg_idx_i == CFG_BASE) base_q <= cfg_wdata_i[11:0];
        else if (cfg_idx_i == CFG_RATE) rate_q <= cfg_wdata_i[15:0];
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_r_q <= right_count_i;
            last_l_q <= left_count_i;
            op_q     <= OP_DR;
            state_q  <= ST_MGO;
          end
        end
        ST_MGO: begin
          if (mul_req.start) state_q <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            if (op_q == OP_TH) begin
              div_sel_q <= 1'b0;
              state_q   <= ST_DGO;
            end else if (op_q == OP_MS) begin
              state_q <= ST_OUT;
            end else begin
              op_q    <= op_e'(op_q + 3'd1);
              state_q <= ST_MGO;
            end
          end
        end
        ST_DGO: begin
          state_q <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_done) begin
            if (!div_sel_q) begin
              div_sel_q <= 1'b1;
              state_q   <= ST_DGO;
            end else begin
              op_q    <= OP_MC;
              state_q <= ST_MGO;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            pose_x_q <= nx_q;
            pose_y_q <= ny_q;
            pose_h_q <= pose_h_q + dth_q;  // wraps mod 2^32
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath captures
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dcnt_r_q <= pr34 - rc34;
      dcnt_l_q <= lc34 - pl34;
    end
    if (state_q == ST_MWAIT && mul_done) begin
      unique case (op_q)
        OP_DR: dr_q <= rnd_delta[57:16];  // round half up, floor shift
        OP_DL: dl_q <= rnd_delta[57:16];
        OP_VR: vr_q <= mul_prod[57:0];
        OP_VL: vl_q <= mul_prod[57:0];
        OP_OM: om_q <= mul_prod[55:0];
        OP_TH: th_q <= mul_prod[63:0];
        OP_MC: nx_q <= pos_step(pose_x_q, mul_prod);
        OP_MS: ny_q <= pos_step(pose_y_q, mul_prod);
        default: ;
      endcase
    end
    if (state_q == ST_DGO) div_neg_q <= div_snum[63];
    if (state_q == ST_DWAIT && div_done) begin
      if (!div_sel_q) omega_q <= sat32(div_sq);
      else dth_q <= div_sq[31:0];
    end
    if (out_load) begin
      x_pos_q   <= nx_q;
      y_pos_q   <= ny_q;
      heading_q <= pose_h_q + dth_q;
      rs_q      <= sat32({{6{vr_q[57]}}, vr_q});
      ls_q      <= sat32({{6{vl_q[57]}}, vl_q});
      lin_q     <= sat32({{5{vsum[58]}}, vsum});
      ang_q     <= omega_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign x_pos_o         = x_pos_q;
  assign y_pos_o         = y_pos_q;
  assign heading_o       = heading_q;
  assign right_speed_o   = rs_q;
  assign left_speed_o    = ls_q;
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = ang_q;

  // checks
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MWAIT)
    else $error("multiplier finished outside its wait state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DWAIT)
    else $error("divider finished outside its wait state");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MGO && !in_ready_o))
    else $error("accepted transaction did not start the schedule");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && state_q == ST_IDLE))
    else $error("result load did not present a result");

endmodule
